// ===== rtl/pttt_pkg.sv =====
`timescale 1ns / 1ps

package pttt_pkg;

   localparam int CMD_W     = 2;
   localparam int ID_W      = 8;
   localparam int DATA_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 5;

   // at most this many fired beats per tick; later firings still reload
   localparam int RESULT_CAP = 16;
   localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   task_id;
      logic [DATA_W-1:0] interval;
   } req_type;

   typedef struct packed {
      logic                fired;
      logic [ID_W-1:0]     fired_id;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  entry_total;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [DATA_W-1:0] reload;
      logic [DATA_W-1:0] countdown;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_TICK,
      S_FLUSH,
      S_DSRCH,
      S_DSHIFT,
      S_REPLY
   } state_type;

endpackage

// ===== rtl/pttt_div.sv =====
`timescale 1ns / 1ps

// Divide by a constant through a reciprocal multiply; quotient registered from start.
// The reciprocal is rounded up with DATA_W + clog2(DIVISOR) fraction bits, which
// keeps the quotient exact for every DATA_W-bit dividend.
module pttt_div
   import pttt_pkg::*;
#(
   parameter int DIVISOR = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int LOG_D  = $clog2(DIVISOR);
   localparam int SHIFT  = DATA_W + LOG_D;
   localparam int PROD_W = DATA_W + SHIFT;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

   logic              done_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [PROD_W-1:0] product;

   always_comb begin
      product = PROD_W'(dividend) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= product[SHIFT +: DATA_W];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/periodic_task_timer_table.sv =====
`timescale 1ns / 1ps

// Channel | direction | handshake           | payload
// req_    | in        | req_valid/req_stall | req_type: cmd, task_id, interval
// rsp_    | out       | rsp_valid/rsp_stall | rsp_type: fired, fired_id, status,
//         |           |                     |   entry_total, last
//
// One item at a time; req_stall is high from acceptance until the last beat is
// loaded into the output register. Table in one synchronous RAM, registered read.
// A tick walks the entries through the read port, one per cycle unless a firing
// is blocked; a delete searches for the match, then shifts later entries down
// by one; an insert runs the reciprocal divide; an empty, full or unknown command
// goes straight to the reply. Reset: synchronous, clears control state, count
// and output valid, not the table RAM. A stalled output holds REPLY and FLUSH,
// and freezes the tick walk when a new firing finds an earlier one still held.
module periodic_task_timer_table
   import pttt_pkg::*;
#(
   parameter int MAX_TASKS   = 16,
   parameter int TICK_PERIOD = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   // table RAM
   entry_type entry_mem_ff [MAX_TASKS];
   entry_type rd_data_ff;
   logic      rd_en;
   logic [IW-1:0] rd_addr;
   logic      wr_en;
   logic [IW-1:0] wr_addr;
   entry_type wr_data;

   // control
   state_type          state_ff,   state_in;
   logic [CW-1:0]      count_ff,   count_in;
   logic [CW-1:0]      rd_idx_ff,  rd_idx_in;
   logic [CW-1:0]      wb_idx_ff,  wb_idx_in;
   logic [CW-1:0]      dst_ff,     dst_in;
   logic               pend_ff,    pend_in;
   logic               held_v_ff,  held_v_in;
   logic [ID_W-1:0]    held_id_ff, held_id_in;
   logic [RCNT_W-1:0]  rep_cnt_ff, rep_cnt_in;
   logic [ID_W-1:0]    id_ff,      id_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // output register
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    out_load;
   rsp_type out_data;
   logic    out_free;

   // divider
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;

   logic               rd_issue;
   logic               fire;
   logic               report;
   logic               blocked;
   logic [TOTAL_W-1:0] total;

   pttt_div #(
      .DIVISOR(TICK_PERIOD)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(req_data.interval),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      rd_issue = (rd_idx_ff < count_ff);
      fire     = (rd_data_ff.countdown == '0);
      report   = fire && (rep_cnt_ff < RCNT_W'(RESULT_CAP));
      blocked  = pend_ff && report && held_v_ff && !out_free;
      total    = TOTAL_W'(count_ff);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      wb_idx_in  = wb_idx_ff;
      dst_in     = dst_ff;
      pend_in    = pend_ff;
      held_v_in  = held_v_ff;
      held_id_in = held_id_ff;
      rep_cnt_in = rep_cnt_ff;
      id_in      = id_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_idx_ff[IW-1:0];
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      out_load   = 1'b0;
      out_data   = '0;
      div_start  = 1'b0;
      req_stall  = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rd_idx_in = '0;
               pend_in   = 1'b0;
               id_in     = req_data.task_id;
               unique case (req_data.cmd)
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_REPLY;
                     end else begin
                        held_v_in  = 1'b0;
                        rep_cnt_in = '0;
                        state_in   = S_TICK;
                     end
                  end
                  CMD_INSERT: begin
                     if (count_ff >= CW'(MAX_TASKS)) begin
                        status_in = STAT_FULL;
                        state_in  = S_REPLY;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_REPLY;
                     end else begin
                        state_in = S_DSRCH;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                     state_in  = S_REPLY;
                  end
               endcase
            end
         end

         S_DIV: begin
            // append the new task at the tail; it fires on the next tick
            if (div_done) begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[IW-1:0];
               wr_data   = '{task_id: id_ff, reload: div_quo, countdown: '0};
               count_in  = count_ff + 1'b1;
               status_in = STAT_OK;
               state_in  = S_REPLY;
            end
         end

         S_TICK: begin
            // read entry k while writing back entry k-1; hold both on a blocked push
            if (!blocked) begin
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = wb_idx_ff[IW-1:0];
                  wr_data = rd_data_ff;
                  wr_data.countdown = fire ? rd_data_ff.reload
                                           : rd_data_ff.countdown - 1'b1;
                  if (report) begin
                     if (held_v_ff) begin
                        out_load = 1'b1;
                        out_data = '{fired: 1'b1, fired_id: held_id_ff, status: STAT_OK,
                                     entry_total: total, last: 1'b0};
                     end
                     held_v_in  = 1'b1;
                     held_id_in = rd_data_ff.task_id;
                     rep_cnt_in = rep_cnt_ff + 1'b1;
                  end
               end
               rd_en     = rd_issue;
               pend_in   = rd_issue;
               wb_idx_in = rd_idx_ff;
               if (rd_issue) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
               if (!pend_ff && !rd_issue) begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            // release the held firing as the last beat, or a no-fire beat
            if (out_free) begin
               out_load = 1'b1;
               out_data = '{fired: held_v_ff,
                            fired_id: held_v_ff ? held_id_ff : '0,
                            status: STAT_OK, entry_total: total, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_DSRCH: begin
            if (pend_ff && rd_data_ff.task_id == id_ff) begin
               // match: shift everything after it down by one
               rd_idx_in = wb_idx_ff + 1'b1;
               dst_in    = wb_idx_ff;
               pend_in   = 1'b0;
               state_in  = S_DSHIFT;
            end else begin
               rd_en     = rd_issue;
               pend_in   = rd_issue;
               wb_idx_in = rd_idx_ff;
               if (rd_issue) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
               if (!pend_ff && !rd_issue) begin
                  status_in = STAT_NOT_FOUND;
                  state_in  = S_REPLY;
               end
            end
         end

         S_DSHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff[IW-1:0];
               wr_data = rd_data_ff;
               dst_in  = dst_ff + 1'b1;
            end
            rd_en   = rd_issue;
            pend_in = rd_issue;
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (!pend_ff && !rd_issue) begin
               count_in  = count_ff - 1'b1;
               status_in = STAT_OK;
               state_in  = S_REPLY;
            end
         end

         S_REPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = '{fired: 1'b0, fired_id: '0, status: status_ff,
                            entry_total: total, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         wb_idx_ff    <= '0;
         dst_ff       <= '0;
         pend_ff      <= 1'b0;
         held_v_ff    <= 1'b0;
         rep_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         wb_idx_ff  <= wb_idx_in;
         dst_ff     <= dst_in;
         pend_ff    <= pend_in;
         held_v_ff  <= held_v_in;
         rep_cnt_ff <= rep_cnt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_id_ff <= held_id_in;
      id_ff      <= id_in;
      status_ff  <= status_in;
      if (out_load) begin
         rsp_ff <= out_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/pttt_chk.sv =====
`timescale 1ns / 1ps

module pttt_chk
   import pttt_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken before the first finished");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fired |-> rsp_data.status == STAT_OK)
      else $error("fired beat with non-ok status");

   a_nofire_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.fired |-> rsp_data.last && rsp_data.fired_id == '0)
      else $error("non-fired beat must be the only, final beat");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_TASKS > 31) || (rsp_data.entry_total <= TOTAL_W'(MAX_TASKS)))
      else $error("entry total above table depth");

endmodule

bind periodic_task_timer_table pttt_chk #(.MAX_TASKS(MAX_TASKS)) u_pttt_chk (.*);
